>>> src/i2d_pkg.sv
`timescale 1ns / 1ps

package i2d_pkg;

    // Default width of the signed input value
    localparam int VALUE_WIDTH_DEF = 32;

    // ASCII codes used in the output text
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [7:0] ASCII_NEWLINE = 8'h0A;

    // Decimal digits needed for a magnitude of up to 2^(w-1):
    // floor(w * log10(2)) + 1, with log10(2) ~ 0.30103
    function automatic int i2d_num_digits(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

    // Sequencer commands to the converter
    typedef struct packed {
        logic start;        // load magnitude, clear BCD, begin shifting
        logic digit_shift;  // drop the top BCD digit, shift the rest up
    } t_conv_ctl;

    // Converter status back to the sequencer
    typedef struct packed {
        logic       busy;       // shift-add-3 pass in progress
        logic [3:0] top_digit;  // most significant BCD digit
    } t_conv_stat;

endpackage

>>> src/i2d_if.sv
`timescale 1ns / 1ps

// Input channel: one signed value per item
interface i2d_value_if #(
    parameter int VALUE_WIDTH = i2d_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one ASCII character per item
interface i2d_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface

>>> src/int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Signed integer to decimal ASCII text.
// i_in carries one two's complement value per item (valid/ready). o_out
// carries the text one character per item: '-' for a negative value, the
// decimal digits most significant first without leading zeros (zero is a
// single '0'), then a newline with last set.
// Sequence: the accept, then the shift-add-3 converter (one magnitude bit per
// cycle) and a check in S_CONV that it has finished; then '-' when negative.
// Each of the NUM_DIGITS digit positions is then dropped as a leading zero or
// sent, with a step to leave the zero skip, and the newline comes last. The
// time per item does not depend on the digit count while o_out does not stall;
// the converter pass sets the bulk of it. One value is handled at a time:
// i_in.ready is high only while no conversion is in flight, though the
// final newline may still sit in the output register waiting to be taken.
// A stall on o_out holds the current character and pauses the sequence;
// nothing is dropped. Reset returns to idle and empties the output register.
module int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = i2d_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2d_value_if.sink   i_in,
    i2d_text_if.source  o_out
);
    import i2d_pkg::*;

    localparam int NUM_DIGITS = i2d_num_digits(VALUE_WIDTH);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_SKIP,
        S_DIGIT,
        S_NL
    } t_state;

    t_state              r_state, n_state;
    logic                r_neg, n_neg;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_o_valid, n_o_valid;
    logic [7:0]          r_o_char, n_o_char;
    logic                r_o_last, n_o_last;

    t_conv_ctl              w_ctl;
    t_conv_stat             w_stat;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_accept;
    logic                   w_free;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_free     = !r_o_valid || o_out.ready;

    // Magnitude in an unsigned word; the most negative value maps exactly
    assign w_mag = i_in.value[VALUE_WIDTH-1] ? (~i_in.value + VALUE_WIDTH'(1))
                                             : i_in.value;

    i2d_conv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_mag   (w_mag),
        .o_stat  (w_stat)
    );

    // Sequencer: convert, then sign, leading zero skip, digits, newline
    always_comb begin
        n_state   = r_state;
        n_neg     = r_neg;
        n_left    = r_left;
        n_o_valid = r_o_valid;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        w_ctl     = '0;

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.start = 1'b1;
                    n_neg       = i_in.value[VALUE_WIDTH-1];
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                if (!w_stat.busy) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = r_neg ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN: begin
                if (w_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = ASCII_MINUS;
                    n_o_last  = 1'b0;
                    n_state   = S_SKIP;
                end
            end
            S_SKIP: begin
                // Drop leading zeros but keep at least one digit
                if (w_stat.top_digit == 4'd0 && r_left > LEFT_W'(1)) begin
                    w_ctl.digit_shift = 1'b1;
                    n_left            = r_left - LEFT_W'(1);
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_free) begin
                    n_o_valid         = 1'b1;
                    n_o_char          = ASCII_ZERO + {4'h0, w_stat.top_digit};
                    n_o_last          = 1'b0;
                    w_ctl.digit_shift = 1'b1;
                    n_left            = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_NL;
                    end
                end
            end
            S_NL: begin
                if (w_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = ASCII_NEWLINE;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_neg    <= n_neg;
        r_left   <= n_left;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.text_char = r_o_char;
    assign o_out.last      = r_o_last;

endmodule

>>> src/i2d_conv.sv
`timescale 1ns / 1ps

// Iterative binary to BCD converter (shift-add-3), one magnitude bit per cycle
module i2d_conv #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  i2d_pkg::t_conv_ctl       i_ctl,
    input  logic [VALUE_WIDTH-1:0]   i_mag,
    output i2d_pkg::t_conv_stat      o_stat
);
    import i2d_pkg::*;

    localparam int NUM_DIGITS = i2d_num_digits(VALUE_WIDTH);
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [BCD_W-1:0]       w_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    // Next state: load, shift step, or digit drop during emission
    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_ctl.start) begin
            n_mag = i_mag;
            n_bcd = '0;
            n_cnt = CNT_W'(VALUE_WIDTH);
        end else if (r_cnt != '0) begin
            n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
            n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
        end else if (i_ctl.digit_shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_mag <= n_mag;
        r_bcd <= n_bcd;
    end

    assign o_stat.busy      = (r_cnt != '0);
    assign o_stat.top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

>>> bench/tb_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii;
    import i2d_pkg::*;

    localparam int VW          = VALUE_WIDTH_DEF;
    localparam int N_DIRECTED  = 20;
    localparam int N_RANDOM    = 390;
    localparam int N_CALM_TAIL = 40;    // last items run with no idling
    localparam int STUCK_LIMIT = 2000;  // cycles with no item moving on either side
    localparam int DRAIN_WAIT  = 80;

    // One expected character of the output text
    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } t_text_item;

    logic i_clk;
    logic i_rst_n;

    i2d_value_if #(.VALUE_WIDTH(VW)) vif ();
    i2d_text_if                      tif ();

    int_to_decimal_ascii #(.VALUE_WIDTH(VW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (vif),
        .o_out   (tif)
    );

    t_text_item text_fifo[$];
    int         mismatch_count;
    int         stuck_cycles;
    bit         calm_tail;
    bit         calm_stretch;

    // Directed values; text typed in only where it is obvious, else predicted
    logic signed [VW-1:0] dir_value [N_DIRECTED] = '{
        0, 1, -1, 32'h7FFF_FFFF, 32'h8000_0000, 9, 10, -10,
        99, 100, -100, 999999999, 1000000000, -1000000000,
        1234567890, -1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h8000_0001, 32'h7FFF_FFFE
    };
    string dir_text [N_DIRECTED] = '{
        "0", "1", "-1", "2147483647", "-2147483648", "9", "10", "-10",
        "", "", "", "", "", "", "", "", "", "", "", ""
    };

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Expected decimal text of one value: sign, digits MSD first, newline
    task automatic predict_text(input logic signed [VW-1:0] val);
        logic [VW-1:0] mag;
        logic [7:0]    digs [0:23];
        int            nd;
        mag = val[VW-1] ? (~val + 1'b1) : val;
        nd  = 0;
        do begin
            digs[nd] = ASCII_ZERO + 8'(mag % 10);
            mag      = mag / 10;
            nd++;
        end while (mag != 0 && nd < 24);
        if (val[VW-1])
            text_fifo.push_back('{ASCII_MINUS, 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            text_fifo.push_back('{digs[i], 1'b0});
        text_fifo.push_back('{ASCII_NEWLINE, 1'b1});
    endtask

    // Typed-in text plus closing newline
    task automatic push_typed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_fifo.push_back('{8'(s[i]), 1'b0});
        text_fifo.push_back('{ASCII_NEWLINE, 1'b1});
    endtask

    // Random value: full range, short numbers, powers of ten +-1, extremes, random bit lengths
    function automatic logic signed [VW-1:0] pick_value();
        logic signed [VW-1:0] val;
        logic [VW-1:0]        p10;
        int                   sel;
        sel = $urandom_range(0, 6);
        case (sel)
            0, 1: val = $urandom;
            2: val = $urandom_range(0, 999);
            3: begin
                p10 = 1;
                repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                val = p10 + $urandom_range(0, 2) - 1;
            end
            4: begin
                case ($urandom_range(0, 5))
                    0: val = 32'h8000_0000;
                    1: val = 32'h8000_0001;
                    2: val = 32'h7FFF_FFFF;
                    3: val = 32'h7FFF_FFFE;
                    4: val = 0;
                    default: val = -1;
                endcase
            end
            default: val = $urandom >> $urandom_range(0, 31);
        endcase
        if (sel >= 2 && sel != 4 && $urandom_range(0, 1) == 1)
            val = -val;
        return val;
    endfunction

    // Send one value; an empty text means the predictor supplies the expectation
    task automatic send_value(input logic signed [VW-1:0] val, input string s);
        if (!calm_tail && !calm_stretch && $urandom_range(0, 3) == 0) begin
            vif.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        vif.valid <= 1'b1;
        vif.value <= val;
        do @(posedge i_clk); while (!vif.ready);
        if (s.len() == 0)
            predict_text(val);
        else
            push_typed_text(s);
    endtask

    // Reset, stimulus, drain and verdict
    initial begin
        vif.valid      = 1'b0;
        vif.value      = '0;
        i_rst_n        = 1'b0;
        mismatch_count = 0;
        calm_tail      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_value(dir_value[i], dir_text[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - N_CALM_TAIL)
                calm_tail = 1'b1;
            send_value(pick_value(), "");
        end
        vif.valid <= 1'b0;

        while (text_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && text_fifo.size() == 0) begin
            $display("[int_to_decimal_ascii] OK");
        end else begin
            $display("[int_to_decimal_ascii] ERROR");
        end
        $finish;
    end

    // Receiver: random stall bursts, with stall-free stretches and tail
    initial begin
        int stall_left;
        int stretch_cnt;
        tif.ready    = 1'b0;
        calm_stretch = 1'b0;
        stall_left   = 0;
        stretch_cnt  = 0;
        forever begin
            @(posedge i_clk);
            stretch_cnt++;
            if (stretch_cnt == 300) begin
                stretch_cnt  = 0;
                calm_stretch = ($urandom_range(0, 3) == 0);
            end
            if (calm_tail || calm_stretch)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0) begin
                tif.ready <= 1'b0;
                stall_left--;
            end else begin
                tif.ready <= 1'b1;
            end
        end
    end

    // Output check against the oldest expected character, plus watchdog
    always @(posedge i_clk) begin
        t_text_item want;
        if (i_rst_n) begin
            if (tif.valid && tif.ready) begin
                if (text_fifo.size() == 0) begin
                    $error("unexpected char: text_char=%h last=%b",
                           tif.text_char, tif.last);
                    mismatch_count++;
                end else begin
                    want = text_fifo.pop_front();
                    if (tif.text_char !== want.text_char) begin
                        $error("text_char: expected %h, got %h",
                               want.text_char, tif.text_char);
                        mismatch_count++;
                    end
                    if (tif.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, tif.last);
                        mismatch_count++;
                    end
                end
            end

            if ((vif.valid && vif.ready) || (tif.valid && tif.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("[int_to_decimal_ascii] ERROR");
                $finish;
            end
        end else begin
            stuck_cycles = 0;
        end
    end

endmodule
